/* src/rsfp_pkg.sv */
// ----------------------------------------------------------------------------
// Range sensor frame parser package
// Frame constants and shared types for the nine-byte frame parser.
// ----------------------------------------------------------------------------
package rsfp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h59;
    localparam int         POS_W       = 4;
    localparam int         PAYLOAD_N   = 4;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [7:0]       t_byte;
    typedef logic [15:0]      t_value;

    // Byte positions within a frame.
    localparam t_pos POS_HDR0    = 4'd0;
    localparam t_pos POS_HDR1    = 4'd1;
    localparam t_pos POS_DIST_L  = 4'd2;
    localparam t_pos POS_STR_H   = 4'd5;
    localparam t_pos FRAME_LAST  = 4'd8;

endpackage

/* src/range_sensor_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// Range sensor frame parser core
// A checksum word passes through the input register, then the result register.
// Throughput: one word per cycle unless the output stalls, set by the single
// input and result registers. Position, sum and held values form an update loop.
// Reset is synchronous and active low; it clears position, sum, held values and
// both valid flags. Payload bytes are not reset.
// ----------------------------------------------------------------------------
// Hunts for nine-byte frames with two header bytes and an 8-bit additive checksum,
// and reports the latest good distance and strength once per completed frame.
// ----------------------------------------------------------------------------
module range_sensor_frame_parser_core
    import rsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_distance_value,
    output logic [15:0] o_strength_value,
    output logic        o_checksum_good
);

    logic   r_in_valid;
    t_byte  r_in_byte;
    t_pos   r_pos;
    t_byte  r_sum;
    t_byte  r_payload [PAYLOAD_N];
    t_value r_held_distance;
    t_value r_held_strength;
    logic   r_out_valid;
    t_value r_out_distance;
    t_value r_out_strength;
    logic   r_out_good;

    t_pos   n_pos;
    t_byte  n_sum;
    t_value n_distance;
    t_value n_strength;
    logic   n_good;
    logic   n_result;
    t_pos   pos_eff;
    logic   adv;
    logic   step;

    // The stage moves whenever the result register is free or being drained.
    assign adv        = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    assign pos_eff = (r_pos > FRAME_LAST) ? POS_HDR0 : r_pos;

    always_comb begin
        n_pos      = pos_eff + t_pos'(1);
        n_sum      = r_sum + r_in_byte;
        n_good     = 1'b0;
        n_result   = 1'b0;
        n_distance = r_held_distance;
        n_strength = r_held_strength;
        case (pos_eff)
            POS_HDR0: begin
                if (r_in_byte == HEADER_BYTE) begin
                    n_sum = r_in_byte;
                end else begin
                    n_sum = '0;
                    n_pos = POS_HDR0;
                end
            end
            POS_HDR1: begin
                if (r_in_byte != HEADER_BYTE) begin
                    n_sum = '0;
                    n_pos = POS_HDR0;
                end
            end
            FRAME_LAST: begin
                n_result = 1'b1;
                n_good   = (r_in_byte == r_sum);
                n_sum    = '0;
                n_pos    = POS_HDR0;
                if (n_good) begin
                    n_distance = {r_payload[1], r_payload[0]};
                    n_strength = {r_payload[3], r_payload[2]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_pos           <= POS_HDR0;
            r_sum           <= '0;
            r_held_distance <= '0;
            r_held_strength <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_pos           <= n_pos;
                r_sum           <= n_sum;
                r_held_distance <= n_distance;
                r_held_strength <= n_strength;
            end
            if (adv) begin
                r_out_valid <= step && n_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && pos_eff >= POS_DIST_L && pos_eff <= POS_STR_H) begin
            r_payload[2'(pos_eff - POS_DIST_L)] <= r_in_byte;
        end
        if (step && n_result) begin
            r_out_distance <= n_distance;
            r_out_strength <= n_strength;
            r_out_good     <= n_good;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_distance_value = r_out_distance;
    assign o_strength_value = r_out_strength;
    assign o_checksum_good  = r_out_good;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_LAST)
        else $error("frame position out of range");

    a_result_after_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && pos_eff == FRAME_LAST |=> r_out_valid)
        else $error("checksum word gave no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !(step && pos_eff == FRAME_LAST) |=> !r_out_valid)
        else $error("result without checksum word");

    a_bad_keeps_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_good |->
            r_out_distance == r_held_distance && r_out_strength == r_held_strength)
        else $error("bad frame changed held values");
`endif

endmodule
